/* hdl/ipv4hp_pkg.sv */
// Shared types and constants for the IPv4 header parser.
// No dependencies; imported by ipv4hp_check and ipv4_header_parser_core.
`timescale 1ns / 1ps

package ipv4hp_pkg;

   // Byte counter width and its saturation value
   localparam int COUNT_BITS = 16;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // Header bytes kept for field extraction
   localparam int HDR_MIN = 20;

   localparam logic [3:0]  IP_VERSION  = 4'h4;
   localparam logic [3:0]  IHL_MIN     = 4'd5;
   localparam logic [15:0] SUM_GOOD    = 16'hFFFF;

   // Result bus width: 158 field bits padded to whole bytes
   localparam int RSP_BITS = 160;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_SHORT   = 2'd1,
      STATUS_BAD_HDR = 2'd2,
      STATUS_BAD_SUM = 2'd3
   } status_type;

   typedef logic [HDR_MIN-1:0][7:0] hdr_bytes_type;

   // Per-packet state as seen after the final byte
   typedef struct packed {
      logic [COUNT_BITS-1:0] byte_count;
      logic [3:0]            ihl;
      logic [3:0]            version;
      logic [15:0]           sum;
   } pkt_state_type;

   typedef struct packed {
      status_type  status;
      logic [3:0]  header_words;
      logic [7:0]  service_type;
      logic [15:0] total_length;
      logic [15:0] ident;
      logic [2:0]  frag_flags;
      logic [12:0] frag_pos;
      logic [7:0]  time_to_live;
      logic [7:0]  protocol_num;
      logic [31:0] source_addr;
      logic [31:0] dest_addr;
      logic [15:0] payload_length;
   } rsp_fields_type;

endpackage

/* hdl/ipv4hp_check.sv */
// Header validation and field decode for the IPv4 header parser.
// Purely combinational; depends on ipv4hp_pkg.
`timescale 1ns / 1ps

module ipv4hp_check (
   input  ipv4hp_pkg::pkt_state_type  pkt,
   input  ipv4hp_pkg::hdr_bytes_type  hdr,
   output ipv4hp_pkg::rsp_fields_type fields
);
   import ipv4hp_pkg::*;

   logic [COUNT_BITS-1:0] hdr_len;
   logic [COUNT_BITS-1:0] total_ext;
   logic [15:0]           total;
   logic [15:0]           frag_word;

   assign hdr_len   = COUNT_BITS'({pkt.ihl, 2'b00});
   assign total     = {hdr[2], hdr[3]};
   assign total_ext = COUNT_BITS'(total);
   assign frag_word = {hdr[6], hdr[7]};

   always_comb begin
      fields = '0;
      // First failing check decides the status; fields stay zero on error
      if (pkt.byte_count < COUNT_BITS'(HDR_MIN)) begin
         fields.status = STATUS_SHORT;
      end else if (pkt.version != IP_VERSION || pkt.ihl < IHL_MIN) begin
         fields.status = STATUS_BAD_HDR;
      end else if (pkt.byte_count < hdr_len) begin
         fields.status = STATUS_SHORT;
      end else if (pkt.sum != SUM_GOOD) begin
         fields.status = STATUS_BAD_SUM;
      end else if (total_ext < hdr_len) begin
         fields.status = STATUS_BAD_HDR;
      end else if (total_ext > pkt.byte_count) begin
         fields.status = STATUS_SHORT;
      end else begin
         fields.status         = STATUS_OK;
         fields.header_words   = pkt.ihl;
         fields.service_type   = hdr[1];
         fields.total_length   = total;
         fields.ident          = {hdr[4], hdr[5]};
         fields.frag_flags     = frag_word[15:13];
         fields.frag_pos       = frag_word[12:0];
         fields.time_to_live   = hdr[8];
         fields.protocol_num   = hdr[9];
         fields.source_addr    = {hdr[12], hdr[13], hdr[14], hdr[15]};
         fields.dest_addr      = {hdr[16], hdr[17], hdr[18], hdr[19]};
         fields.payload_length = total - 16'({pkt.ihl, 2'b00});
      end
   end

endmodule

/* hdl/ipv4_header_parser_core.sv */
// IPv4 header parser: byte stream in, one status and field record per packet out.
// Top level; depends on ipv4hp_pkg and ipv4hp_check.
//
// Input channel req_*: one packet byte per transfer in req_tdata, header first,
// with req_tlast high on the final byte of the packet. A byte is taken at any
// clock edge where req_tvalid and req_tready are both high.
// Result channel rsp_*: one transfer per packet, produced by the req_tlast byte.
// It carries the status (ok, too short, bad header, bad checksum) and the
// decoded header fields; all fields but the status read zero on an error.
// Throughput is one byte per cycle, including across packet boundaries. The
// result appears on rsp_tvalid the cycle after the final byte is taken: the
// byte counter, checksum adder and header capture registers are updated in the
// accepting cycle and the decoded record is captured in a single result register.
// If the receiver holds rsp_tready low, the result register stays full and
// req_tready falls until it drains; bytes that produce no result are held too.
// Synchronous reset clears the counter, checksum, header nibbles and the
// result valid; captured header bytes are not reset.
`timescale 1ns / 1ps

module ipv4_header_parser_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [7:0]                   req_tdata,   // [7:0] data_byte
   input  logic                         req_tlast,   // last_byte
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // [1:0] status, [5:2] header_words, [13:6] service_type, [29:14] total_length,
   // [45:30] ident, [48:46] frag_flags, [61:49] frag_pos, [69:62] time_to_live,
   // [77:70] protocol_num, [109:78] source_addr, [141:110] dest_addr,
   // [157:142] payload_length, [159:158] zero
   output logic [ipv4hp_pkg::RSP_BITS-1:0] rsp_tdata
);
   import ipv4hp_pkg::*;

   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [3:0]            ihl_ff, ihl_in;
   logic [3:0]            version_ff, version_in;
   logic [15:0]           sum_ff, sum_in;
   logic [7:0]            pend_ff, pend_in;
   hdr_bytes_type         hdr_ff, hdr_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_fields_type        rsp_ff, rsp_in;

   logic                  take;
   logic                  first_byte;
   logic                  in_header;
   logic [16:0]           sum_raw;
   logic [15:0]           sum_next;
   logic [COUNT_BITS-1:0] count_next;
   pkt_state_type         pkt_end;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign take       = req_tvalid && req_tready;
   assign first_byte = (count_ff == '0);

   always_comb begin
      ihl_in     = first_byte ? req_tdata[3:0] : ihl_ff;
      version_in = first_byte ? req_tdata[7:4] : version_ff;

      // Capture the first twenty bytes
      hdr_in = hdr_ff;
      for (int i = 0; i < HDR_MIN; i++) begin
         if (count_ff == COUNT_BITS'(i)) begin
            hdr_in[i] = req_tdata;
         end
      end

      // Ones' complement sum over the IHL*4 header bytes, end-around carry
      in_header = (count_ff < COUNT_BITS'({ihl_in, 2'b00}));
      sum_raw   = {1'b0, sum_ff} + {1'b0, pend_ff, req_tdata};
      sum_next  = sum_ff;
      pend_in   = pend_ff;
      if (in_header) begin
         if (!count_ff[0]) begin
            pend_in = req_tdata;
         end else begin
            sum_next = sum_raw[15:0] + {15'b0, sum_raw[16]};
         end
      end

      count_next = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;

      pkt_end.byte_count = count_next;
      pkt_end.ihl        = ihl_in;
      pkt_end.version    = version_in;
      pkt_end.sum        = sum_next;

      sum_in   = sum_next;
      count_in = count_next;
      // Clear per-packet state once the final byte is in
      if (req_tlast) begin
         count_in   = '0;
         ihl_in     = '0;
         version_in = '0;
         sum_in     = '0;
         pend_in    = '0;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (take && req_tlast) begin
         rsp_valid_in = 1'b1;
      end
   end

   ipv4hp_check u_check (
      .pkt    (pkt_end),
      .hdr    (hdr_in),
      .fields (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ihl_ff       <= '0;
         version_ff   <= '0;
         sum_ff       <= '0;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            count_ff   <= count_in;
            ihl_ff     <= ihl_in;
            version_ff <= version_in;
            sum_ff     <= sum_in;
            pend_ff    <= pend_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         hdr_ff <= hdr_in;
         if (req_tlast) begin
            rsp_ff <= rsp_in;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00,
                        rsp_ff.payload_length,
                        rsp_ff.dest_addr,
                        rsp_ff.source_addr,
                        rsp_ff.protocol_num,
                        rsp_ff.time_to_live,
                        rsp_ff.frag_pos,
                        rsp_ff.frag_flags,
                        rsp_ff.ident,
                        rsp_ff.total_length,
                        rsp_ff.service_type,
                        rsp_ff.header_words,
                        rsp_ff.status};

endmodule
